@@ hdl/phase_counter_accumulator_defines.svh @@
// Assertion macros shared by the phase counter accumulator RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef PHASE_COUNTER_ACCUMULATOR_DEFINES_SVH
`define PHASE_COUNTER_ACCUMULATOR_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define PCA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pca_pkg.sv @@
// Package for the phase counter accumulator: request and result words,
// request codes and the control structs passed between the lanes and the merge stage.
`default_nettype none

package pca_pkg;

    localparam int NUM_CTRS     = 7;
    localparam int READING_BITS = 48;
    localparam int TOTAL_BITS   = 64;
    localparam int CALL_BITS    = 32;
    localparam int SLOT_BITS    = 5;

    typedef enum logic [1:0] {
        REQ_ENTER = 2'd0,
        REQ_EXIT  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_READ  = 2'd3
    } t_req_type;

    typedef logic [READING_BITS-1:0] t_reading;
    typedef logic [TOTAL_BITS-1:0]   t_total;
    typedef t_reading [NUM_CTRS-1:0] t_readings;
    typedef t_total   [NUM_CTRS-1:0] t_totals;

    typedef struct packed {
        t_req_type              req_type;
        logic [SLOT_BITS-1:0]   slot;
        t_reading               instr_count;
        t_reading               cycle_count;
        t_reading               ref_cycle_count;
        t_reading               l1d_miss_count;
        t_reading               l2_miss_count;
        t_reading               tlb_miss_count;
        t_reading               branch_miss_count;
    } t_req;

    typedef struct packed {
        logic                   status;
        logic [CALL_BITS-1:0]   call_total;
        t_total                 instr_total;
        t_total                 cycle_total;
        t_total                 ref_cycle_total;
        t_total                 l1d_miss_total;
        t_total                 l2_miss_total;
        t_total                 tlb_miss_total;
        t_total                 branch_miss_total;
    } t_rsp;

    typedef struct packed {
        logic [SLOT_BITS-1:0]   slot;
        logic                   snap_we;
        logic                   tot_we;
        logic                   snap_vld;
        logic                   tot_vld;
    } t_lane_cmd;

    typedef struct packed {
        logic                   fire;
        logic                   zero;
        logic                   ignored;
    } t_res_ctrl;

endpackage

`default_nettype wire

@@ hdl/pca_lane.sv @@
// One counter lane: per-slot entry snapshot and 64-bit total memories,
// wrap-aware delta and accumulate. Depends on pca_pkg.
`default_nettype none

module pca_lane #(
    parameter int SLOT_COUNT   = 16,
    parameter int COUNTER_BITS = 48
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rd,
    input  wire logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] i_rd_idx,
    input  wire pca_pkg::t_reading                 i_reading,
    input  wire pca_pkg::t_lane_cmd                i_cmd,
    output pca_pkg::t_total                        o_total
);
    import pca_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [COUNTER_BITS-1:0] snap_mem [SLOT_COUNT];
    t_total                  tot_mem  [SLOT_COUNT];

    logic [COUNTER_BITS-1:0] r_snap_rd;
    t_total                  r_tot_rd;
    logic [COUNTER_BITS-1:0] r_now;
    logic [COUNTER_BITS-1:0] n_now;
    logic [63:0]             w_wide;
    logic [COUNTER_BITS-1:0] w_snap;
    logic [COUNTER_BITS-1:0] w_delta;
    t_total                  w_tot;
    t_total                  w_sum;
    logic [SLOT_W-1:0]       w_idx;

    assign w_wide  = 64'(i_reading);
    assign n_now   = w_wide[COUNTER_BITS-1:0];
    assign w_idx   = i_cmd.slot[SLOT_W-1:0];
    assign w_snap  = i_cmd.snap_vld ? r_snap_rd : '0;
    assign w_tot   = i_cmd.tot_vld ? r_tot_rd : '0;
    assign w_delta = r_now - w_snap;
    assign w_sum   = w_tot + TOTAL_BITS'(w_delta);
    assign o_total = i_cmd.tot_we ? w_sum : w_tot;

    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_snap_rd <= snap_mem[i_rd_idx];
            r_tot_rd  <= tot_mem[i_rd_idx];
            r_now     <= n_now;
        end
        if (i_cmd.snap_we) begin
            snap_mem[w_idx] <= r_now;
        end
        if (i_cmd.tot_we) begin
            tot_mem[w_idx] <= w_sum;
        end
    end

endmodule

`default_nettype wire

@@ hdl/pca_merge.sv @@
// Merge stage: per-slot exit count memory and the registered result word
// built from the lane totals. Depends on pca_pkg.
`default_nettype none

module pca_merge #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_rd,
    input  wire logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] i_rd_idx,
    input  wire pca_pkg::t_lane_cmd                i_cmd,
    input  wire pca_pkg::t_res_ctrl                i_res,
    input  wire pca_pkg::t_totals                  i_totals,
    output logic                                   o_done,
    output pca_pkg::t_rsp                          o_result
);
    import pca_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [CALL_BITS-1:0] cnt_mem [SLOT_COUNT];

    logic [CALL_BITS-1:0] r_cnt_rd;
    logic [CALL_BITS-1:0] w_cnt;
    logic [CALL_BITS-1:0] w_cnt_new;
    logic [SLOT_W-1:0]    w_idx;
    logic                 r_done;
    t_rsp                 r_result;
    t_rsp                 n_result;

    assign w_idx     = i_cmd.slot[SLOT_W-1:0];
    assign w_cnt     = i_cmd.tot_vld ? r_cnt_rd : '0;
    assign w_cnt_new = i_cmd.tot_we ? w_cnt + CALL_BITS'(1) : w_cnt;

    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_cnt_rd <= cnt_mem[i_rd_idx];
        end
        if (i_cmd.tot_we) begin
            cnt_mem[w_idx] <= w_cnt_new;
        end
    end

    always_comb begin
        n_result = '0;
        n_result.status = i_res.ignored;
        if (!i_res.zero) begin
            n_result.call_total        = w_cnt_new;
            n_result.instr_total       = i_totals[0];
            n_result.cycle_total       = i_totals[1];
            n_result.ref_cycle_total   = i_totals[2];
            n_result.l1d_miss_total    = i_totals[3];
            n_result.l2_miss_total     = i_totals[4];
            n_result.tlb_miss_total    = i_totals[5];
            n_result.branch_miss_total = i_totals[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_res.fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.fire) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

@@ hdl/phase_counter_accumulator.sv @@
// Top level of the phase counter accumulator: request decode, slot valid flags,
// seven counter lanes and the merge stage. Depends on pca_pkg, pca_lane, pca_merge.
//
// A request word is taken when start is high and busy is low. For every request the
// accept edge reads the slot's snapshot, total and exit count from the per-lane RAMs,
// and the following cycle forms the wrap-aware deltas, adds them into the 64-bit totals
// and writes the slot back. busy is high for that one cycle, and no new request is taken
// while it is high. The result word is registered on o_result and marked by o_done,
// which is high for exactly one cycle, in the cycle right after busy, starting at the
// edge where busy falls; the receiver cannot stall it and must take it in that cycle.
// o_result holds the word until the next request finishes. A clear-all request uses
// the same steps: per-slot valid flags make every total and exit count read as zero at
// once, and reset clears the table alike, so there is no clearing pass. The
// profiling_enable register is written through the configuration channel, which is always ready.
`default_nettype none
`include "phase_counter_accumulator_defines.svh"

module phase_counter_accumulator #(
    parameter int SLOT_COUNT   = 16,
    parameter int COUNTER_BITS = 48
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire pca_pkg::t_req  i_req,
    output logic                o_done,
    output pca_pkg::t_rsp       o_result,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic           i_cfg_data
);
    import pca_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic                  r_busy;
    t_req_type             r_type;
    logic [SLOT_BITS-1:0]  r_slot;
    logic                  r_enable;
    logic [SLOT_COUNT-1:0] r_snap_vld;
    logic [SLOT_COUNT-1:0] r_tot_vld;

    logic                  w_accept;
    logic                  w_in_range;
    logic [SLOT_W-1:0]     w_idx;
    logic [SLOT_W-1:0]     w_rd_idx;
    logic                  w_enter;
    logic                  w_exit;
    logic                  w_clear;
    logic                  w_act;
    t_lane_cmd             w_cmd;
    t_res_ctrl             w_res;
    t_readings             w_readings;
    t_totals               w_totals;

    assign w_accept    = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;
    assign w_rd_idx    = i_req.slot[SLOT_W-1:0];
    assign w_idx       = r_slot[SLOT_W-1:0];
    assign w_in_range  = ({1'b0, r_slot} < (SLOT_BITS + 1)'(SLOT_COUNT));

    assign w_readings[0] = i_req.instr_count;
    assign w_readings[1] = i_req.cycle_count;
    assign w_readings[2] = i_req.ref_cycle_count;
    assign w_readings[3] = i_req.l1d_miss_count;
    assign w_readings[4] = i_req.l2_miss_count;
    assign w_readings[5] = i_req.tlb_miss_count;
    assign w_readings[6] = i_req.branch_miss_count;

    always_comb begin
        w_enter = 1'b0;
        w_exit  = 1'b0;
        w_clear = 1'b0;
        unique case (r_type)
            REQ_ENTER: w_enter = 1'b1;
            REQ_EXIT:  w_exit  = 1'b1;
            REQ_CLEAR: w_clear = 1'b1;
            REQ_READ:  ;
            default:   ;
        endcase
    end

    always_comb begin
        w_act          = w_in_range && r_enable && (w_enter || w_exit);
        w_cmd.slot     = r_slot;
        w_cmd.snap_we  = r_busy && w_act && w_enter;
        w_cmd.tot_we   = r_busy && w_act && w_exit;
        w_cmd.snap_vld = w_in_range && r_snap_vld[w_idx];
        w_cmd.tot_vld  = w_in_range && r_tot_vld[w_idx];
        w_res.fire     = r_busy;
        w_res.zero     = w_clear || !w_in_range;
        w_res.ignored  = !w_clear && (!w_in_range || ((w_enter || w_exit) && !r_enable));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_enable   <= 1'b0;
            r_snap_vld <= '0;
            r_tot_vld  <= '0;
        end else begin
            r_busy <= w_accept;
            if (i_cfg_valid && o_cfg_ready) begin
                r_enable <= i_cfg_data;
            end
            if (w_cmd.snap_we) begin
                r_snap_vld[w_idx] <= 1'b1;
            end
            if (r_busy && w_clear) begin
                r_tot_vld <= '0;
            end else if (w_cmd.tot_we) begin
                r_tot_vld[w_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_type <= i_req.req_type;
            r_slot <= i_req.slot;
        end
    end

    for (genvar g = 0; g < NUM_CTRS; g++) begin : g_lane
        pca_lane #(
            .SLOT_COUNT   (SLOT_COUNT),
            .COUNTER_BITS (COUNTER_BITS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rd      (w_accept),
            .i_rd_idx  (w_rd_idx),
            .i_reading (w_readings[g]),
            .i_cmd     (w_cmd),
            .o_total   (w_totals[g])
        );
    end

    pca_merge #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd     (w_accept),
        .i_rd_idx (w_rd_idx),
        .i_cmd    (w_cmd),
        .i_res    (w_res),
        .i_totals (w_totals),
        .o_done   (o_done),
        .o_result (o_result)
    );

    `PCA_ASSERT_NEXT(a_accept_busy, w_accept, r_busy, "accepted word did not raise busy")
    `PCA_ASSERT_NEXT(a_busy_one_cycle, r_busy, !r_busy, "busy held for more than one cycle")
    `PCA_ASSERT_NEXT(a_busy_done, r_busy, o_done, "finished word produced no result")
    `PCA_ASSERT_NEXT(a_idle_no_done, !r_busy, !o_done, "result strobe without a request")
    `PCA_ASSERT_NEXT(a_clear_zero, r_busy && w_clear, o_result == '0, "clear result not zero")
    `PCA_ASSERT_SAME(a_one_write, r_busy, !(w_cmd.snap_we && w_cmd.tot_we), "two writes at once")

endmodule

`default_nettype wire
